/* src/dbd_pkg.sv */
// ----------------------------------------------------------------------------
// dbd_pkg
// Shared widths, the month table and the constant divider for the
// Gregorian date difference block.
// ----------------------------------------------------------------------------
package dbd_pkg;

  localparam int unsigned YearW  = 14;
  localparam int unsigned MonthW = 4;
  localparam int unsigned DayW   = 5;
  localparam int unsigned CountW = 22;
  localparam int unsigned OrdW   = 23;  // ordinal of year 16383 fits below 2^23
  localparam int unsigned DoyW   = 10;
  localparam int unsigned QuotW  = 9;   // quotient of a 15-bit value by 100

  localparam int unsigned DivInW     = 15;
  localparam int unsigned DivProdW   = 28;
  localparam int unsigned DivShift   = 19;
  // ceil(2^19 / 100); exact floor(x / 100) for every x below 43690
  localparam logic [12:0] Recip100   = 13'd5243;
  localparam logic [CountW-1:0] DaysMax = {CountW{1'b1}};

  // floor(x / 100) by reciprocal multiplication
  function automatic logic [QuotW-1:0] div100(input logic [DivInW-1:0] x);
    logic [DivProdW-1:0] p;
    p = DivProdW'(x) * DivProdW'(Recip100);
    return p[DivProdW-1:DivShift];
  endfunction

  // days in months 1 .. month-1 of a common year; months above twelve count the full year
  function automatic logic [8:0] cum_before(input logic [MonthW-1:0] m);
    logic [8:0] r;
    case (m)
      4'd2:    r = 9'd31;
      4'd3:    r = 9'd59;
      4'd4:    r = 9'd90;
      4'd5:    r = 9'd120;
      4'd6:    r = 9'd151;
      4'd7:    r = 9'd181;
      4'd8:    r = 9'd212;
      4'd9:    r = 9'd243;
      4'd10:   r = 9'd273;
      4'd11:   r = 9'd304;
      4'd12:   r = 9'd334;
      4'd13,
      4'd14,
      4'd15:   r = 9'd365;
      default: r = 9'd0;
    endcase
    return r;
  endfunction

endpackage

/* src/dbd_ordinal.sv */
// ----------------------------------------------------------------------------
// dbd_ordinal
// Three-stage pipeline turning a date into its day ordinal: days in all
// years before it (year 0 counted, leap) plus its day of year.
// ----------------------------------------------------------------------------
module dbd_ordinal (
  input  logic                            clk,
  input  logic                            en,
  input  logic [dbd_pkg::YearW-1:0]       year,
  input  logic [dbd_pkg::MonthW-1:0]      month,
  input  logic [dbd_pkg::DayW-1:0]        day,
  output logic [dbd_pkg::OrdW-1:0]        ordinal
);

  // stage A: quotients by 100
  logic [dbd_pkg::YearW-1:0]   y_a_r;
  logic [dbd_pkg::MonthW-1:0]  m_a_r;
  logic [dbd_pkg::DayW-1:0]    d_a_r;
  logic [dbd_pkg::QuotW-1:0]   q_y_a_r;    // y / 100
  logic [dbd_pkg::QuotW-1:0]   q_c100_a_r; // (y + 99) / 100
  logic [dbd_pkg::QuotW-1:0]   q_c400_a_r; // (y + 399) / 400

  logic [dbd_pkg::DivInW-1:0]  y_p99;
  logic [dbd_pkg::DivInW-1:0]  y_p399;
  logic [dbd_pkg::DivInW-1:0]  y_p399_q4;

  assign y_p99     = dbd_pkg::DivInW'(year) + dbd_pkg::DivInW'(99);
  assign y_p399    = dbd_pkg::DivInW'(year) + dbd_pkg::DivInW'(399);
  assign y_p399_q4 = y_p399 >> 2;

  always_ff @(posedge clk) begin
    if (en) begin
      y_a_r      <= year;
      m_a_r      <= month;
      d_a_r      <= day;
      q_y_a_r    <= dbd_pkg::div100(dbd_pkg::DivInW'(year));
      q_c100_a_r <= dbd_pkg::div100(y_p99);
      q_c400_a_r <= dbd_pkg::div100(y_p399_q4);
    end
  end

  // stage B: days before the year and day of year
  logic [dbd_pkg::OrdW-1:0]    before_b_r;
  logic [dbd_pkg::DoyW-1:0]    doy_b_r;

  logic [dbd_pkg::YearW-1:0]   hundreds;
  logic                        leap;
  logic [dbd_pkg::DivInW-1:0]  y_p3;
  logic [dbd_pkg::OrdW-1:0]    before_nxt;
  logic [dbd_pkg::DoyW-1:0]    doy_nxt;

  always_comb begin
    hundreds = dbd_pkg::YearW'(q_y_a_r) * dbd_pkg::YearW'(100);
    // divisible by 4, and either not a century or a century divisible by 400
    leap = (y_a_r[1:0] == 2'b00) && ((hundreds != y_a_r) || (q_y_a_r[1:0] == 2'b00));
    y_p3 = dbd_pkg::DivInW'(y_a_r) + dbd_pkg::DivInW'(3);
    before_nxt = dbd_pkg::OrdW'(y_a_r) * dbd_pkg::OrdW'(365)
               + dbd_pkg::OrdW'(y_p3 >> 2)
               - dbd_pkg::OrdW'(q_c100_a_r)
               + dbd_pkg::OrdW'(q_c400_a_r);
    doy_nxt = dbd_pkg::DoyW'(d_a_r) + dbd_pkg::DoyW'(dbd_pkg::cum_before(m_a_r))
            + dbd_pkg::DoyW'(leap && (m_a_r >= 4'd3));
  end

  always_ff @(posedge clk) begin
    if (en) begin
      before_b_r <= before_nxt;
      doy_b_r    <= doy_nxt;
    end
  end

  // stage C: ordinal
  logic [dbd_pkg::OrdW-1:0] ord_c_r;

  always_ff @(posedge clk) begin
    if (en) begin
      ord_c_r <= before_b_r + dbd_pkg::OrdW'(doy_b_r);
    end
  end

  assign ordinal = ord_c_r;

endmodule

/* src/days_between_dates.sv */
// ----------------------------------------------------------------------------
// days_between_dates
// Day distance between two Gregorian dates, fully pipelined.
// ----------------------------------------------------------------------------
// Each input transfer carries a start date, an end date and a count_end_day
// flag; the block answers with one result transfer holding the days from
// start to end (plus one when count_end_day is set). If the start is not
// strictly before the end, order_error is set and day_count is zero. Leap
// years follow the 4/100/400 rule. Both dates go through their own
// three-stage ordinal pipeline (divide by 100 via reciprocal multiply,
// days before the year, ordinal sum) and a fourth stage takes the
// difference, clamps it to 0..4194303 and holds it in the output register.
// Four register stages: out_tvalid rises once an input transfer has passed
// the three ordinal stages and the output register; one item is taken every
// cycle unless the pipeline is stalled. The whole pipeline advances together,
// so a stall on the result side with a result waiting holds every stage, and
// in_tready is high when the last stage is empty or out_tready is high.
// ----------------------------------------------------------------------------
module days_between_dates (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // [13:0] start_year, [17:14] start_month, [22:18] start_day,
  // [36:23] end_year, [40:37] end_month, [45:41] end_day,
  // [46] count_end_day, [47] zero
  input  logic [47:0] in_tdata,
  output logic        out_tvalid,
  input  logic        out_tready,
  // [21:0] day_count, [23:22] zero
  output logic [23:0] out_tdata,
  // [0] order_error
  output logic        out_tuser
);

  localparam int unsigned Stages = 4;

  // input unpacking
  logic [dbd_pkg::YearW-1:0]  start_year, end_year;
  logic [dbd_pkg::MonthW-1:0] start_month, end_month;
  logic [dbd_pkg::DayW-1:0]   start_day, end_day;
  logic                       count_end_day;

  assign start_year    = in_tdata[13:0];
  assign start_month   = in_tdata[17:14];
  assign start_day     = in_tdata[22:18];
  assign end_year      = in_tdata[36:23];
  assign end_month     = in_tdata[40:37];
  assign end_day       = in_tdata[45:41];
  assign count_end_day = in_tdata[46];

  // pipeline advance: last stage empty or being drained
  logic en;
  logic [Stages-1:0] vld_r, vld_nxt;

  assign en        = !vld_r[Stages-1] || out_tready;
  assign in_tready = en;

  always_comb begin
    vld_nxt = {vld_r[Stages-2:0], in_tvalid};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= vld_nxt;
    end
  end

  // date order as (year, month, day) tuples, computed at entry
  logic earlier;

  assign earlier = (start_year < end_year) ||
                   ((start_year == end_year) &&
                    ((start_month < end_month) ||
                     ((start_month == end_month) && (start_day < end_day))));

  // error and increment ride alongside the ordinal stages
  logic [Stages-2:0] err_r;
  logic [Stages-2:0] inc_r;

  always_ff @(posedge clk) begin
    if (en) begin
      err_r <= {err_r[Stages-3:0], !earlier};
      inc_r <= {inc_r[Stages-3:0], count_end_day};
    end
  end

  // ordinal pipelines
  logic [dbd_pkg::OrdW-1:0] ord_start, ord_end;

  dbd_ordinal u_ord_start (
    .clk     (clk),
    .en      (en),
    .year    (start_year),
    .month   (start_month),
    .day     (start_day),
    .ordinal (ord_start)
  );

  dbd_ordinal u_ord_end (
    .clk     (clk),
    .en      (en),
    .year    (end_year),
    .month   (end_month),
    .day     (end_day),
    .ordinal (ord_end)
  );

  // final stage: difference, clamp, output register
  localparam int unsigned DiffW = dbd_pkg::OrdW + 2;

  logic signed [DiffW-1:0]     diff;
  logic [dbd_pkg::CountW-1:0]  count_nxt;
  logic [dbd_pkg::CountW-1:0]  count_r;
  logic                        err_out_r;

  always_comb begin
    diff = signed'(DiffW'(ord_end)) - signed'(DiffW'(ord_start))
         + signed'(DiffW'(inc_r[Stages-2]));
    if (err_r[Stages-2] || diff < 0) begin
      // bad order, or out-of-range days pulling the sum below zero
      count_nxt = '0;
    end else if (diff > signed'(DiffW'(dbd_pkg::DaysMax))) begin
      count_nxt = dbd_pkg::DaysMax;
    end else begin
      count_nxt = diff[dbd_pkg::CountW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      count_r   <= count_nxt;
      err_out_r <= err_r[Stages-2];
    end
  end

  assign out_tvalid = vld_r[Stages-1];
  assign out_tdata  = {2'b00, count_r};
  assign out_tuser  = err_out_r;

  // checks
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tdata[dbd_pkg::CountW-1:0] == '0)
    else $error("order_error with nonzero day_count");

  a_enter: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> vld_r[0])
    else $error("accepted item lost at first stage");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !en |=> $stable(vld_r))
    else $error("pipeline moved during stall");

endmodule

/* test/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Testbench for days_between_dates: day distance between Gregorian dates.
// ----------------------------------------------------------------------------
// Date pairs go in on the input stream with random gaps. Every accepted
// transfer is run through a local day-number calculation, and the expected
// span is queued. Each result transfer is checked against the oldest queued
// span, field by field. A directed part covers ordering errors, the span
// extremes, the leap-year rules and out-of-range fields. A random part
// follows, made of valid date pairs, raw field noise and a long result-side
// stall.
// ----------------------------------------------------------------------------
module tb;

  // a calendar date at the block's field widths
  typedef struct {
    logic [dbd_pkg::YearW-1:0]  y;
    logic [dbd_pkg::MonthW-1:0] m;
    logic [dbd_pkg::DayW-1:0]   d;
  } date_t;

  // one input transfer: span from origin to target
  typedef struct {
    date_t origin;
    date_t target;
    logic  incl_end;
  } date_pair_t;

  // one result transfer
  typedef struct {
    logic [dbd_pkg::CountW-1:0] days;
    logic                       order_err;
  } span_t;

  // days in months 1 .. m-1 of a common year, months 13..15 count the full year
  localparam int MonthStart [16] = '{0, 0, 31, 59, 90, 120, 151, 181, 212, 243,
                                     273, 304, 334, 365, 365, 365};
  localparam longint SpanLimit = (longint'(1) << dbd_pkg::CountW) - 1;

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [47:0] in_tdata   = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [23:0] out_tdata;
  logic        out_tuser;

  span_t       pending_spans[$];   // expected results, oldest first
  int unsigned mismatches  = 0;
  bit          src_gaps_on = 1'b1;
  bit          sink_gaps_on = 1'b1;
  int unsigned hold_req    = 0;    // long receiver stall requested by a test
  int unsigned sink_wait   = 0;    // cycles left in the current receiver stall

  days_between_dates i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // hard stop, far beyond the slowest legal run
  initial begin
    #4000000;
    $display("Mismatches found");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Day-number calculation
  // --------------------------------------------------------------------------

  function automatic bit is_leap(input int unsigned y);
    return (y % 400 == 0) || ((y % 100 != 0) && (y % 4 == 0));
  endfunction

  function automatic int unsigned month_len(input int unsigned y, input int unsigned m);
    return MonthStart[m + 1] - MonthStart[m] + ((m == 2 && is_leap(y)) ? 1 : 0);
  endfunction

  // days since the start of year zero (itself a leap year) up to the date
  function automatic longint day_number(input date_t dt);
    longint yl;
    longint n;
    yl = longint'(dt.y);
    n  = 365 * yl + (yl + 3) / 4 - (yl + 99) / 100 + (yl + 399) / 400;
    n  = n + longint'(dt.d) + MonthStart[dt.m];
    if (dt.m >= 3 && is_leap(dt.y)) n++;
    return n;
  endfunction

  function automatic span_t date_span(input date_pair_t p);
    span_t  r;
    longint diff;
    // fixed-width concatenation compares as a (year, month, day) tuple
    if ({p.origin.y, p.origin.m, p.origin.d} >= {p.target.y, p.target.m, p.target.d}) begin
      r.days      = '0;
      r.order_err = 1'b1;
    end else begin
      diff = day_number(p.target) - day_number(p.origin) + longint'(p.incl_end);
      // bad days can push the span below zero; huge years past the 22-bit range
      if (diff < 0) diff = 0;
      if (diff > SpanLimit) diff = SpanLimit;
      r.days      = diff[dbd_pkg::CountW-1:0];
      r.order_err = 1'b0;
    end
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------

  function automatic int unsigned pick_gap();
    return ($urandom_range(9, 0) == 0) ? $urandom_range(40, 10) : $urandom_range(3, 1);
  endfunction

  function automatic date_pair_t pair_of(input int unsigned sy, input int unsigned sm,
                                         input int unsigned sd, input int unsigned ey,
                                         input int unsigned em, input int unsigned ed,
                                         input bit incl);
    date_pair_t p;
    p.origin.y = dbd_pkg::YearW'(sy);
    p.origin.m = dbd_pkg::MonthW'(sm);
    p.origin.d = dbd_pkg::DayW'(sd);
    p.target.y = dbd_pkg::YearW'(ey);
    p.target.m = dbd_pkg::MonthW'(em);
    p.target.d = dbd_pkg::DayW'(ed);
    p.incl_end = incl;
    return p;
  endfunction

  // century years get extra weight so the 100/400 rules are hit often
  function automatic int unsigned pick_year();
    return ($urandom_range(3, 0) == 0) ? 100 * $urandom_range(99, 1) : $urandom_range(9999, 1);
  endfunction

  function automatic logic [dbd_pkg::DayW-1:0] pick_day(input int unsigned y,
                                                        input int unsigned m);
    return dbd_pkg::DayW'($urandom_range(month_len(y, m), 1));
  endfunction

  function automatic date_pair_t rand_valid_pair();
    date_pair_t  p;
    date_t       t;
    int unsigned kind;
    kind       = $urandom_range(99, 0);
    p.origin.y = dbd_pkg::YearW'(pick_year());
    p.origin.m = dbd_pkg::MonthW'($urandom_range(12, 1));
    p.origin.d = pick_day(p.origin.y, p.origin.m);
    if (kind < 55) begin
      p.target.y = dbd_pkg::YearW'(pick_year());
      p.target.m = dbd_pkg::MonthW'($urandom_range(12, 1));
    end else if (kind < 90) begin
      p.target.y = p.origin.y;
      p.target.m = (kind < 75) ? dbd_pkg::MonthW'($urandom_range(12, 1)) : p.origin.m;
    end else begin
      p.target = p.origin;
    end
    if (kind < 90) p.target.d = pick_day(p.target.y, p.target.m);
    // mostly in order, with a share of reversed pairs for the order check
    if (({p.origin.y, p.origin.m, p.origin.d} > {p.target.y, p.target.m, p.target.d}) !=
        ($urandom_range(6, 0) == 0)) begin
      t        = p.origin;
      p.origin = p.target;
      p.target = t;
    end
    p.incl_end = $urandom_range(1, 0);
    return p;
  endfunction

  function automatic date_pair_t rand_raw_pair();
    date_pair_t p;
    p.origin.y = dbd_pkg::YearW'($urandom);
    p.origin.m = dbd_pkg::MonthW'($urandom);
    p.origin.d = dbd_pkg::DayW'($urandom);
    p.target.y = dbd_pkg::YearW'($urandom);
    p.target.m = dbd_pkg::MonthW'($urandom);
    p.target.d = dbd_pkg::DayW'($urandom);
    p.incl_end = $urandom_range(1, 0);
    return p;
  endfunction

  // one input transfer; tvalid is left high so back-to-back items need no toggle
  task automatic send_dates(input date_pair_t p);
    int unsigned gap;
    if (src_gaps_on && $urandom_range(99, 0) < 30) begin
      gap = pick_gap();
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {1'b0, p.incl_end, p.target.d, p.target.m, p.target.y,
                  p.origin.d, p.origin.m, p.origin.y};
    do @(posedge clk); while (!in_tready);
    pending_spans.push_back(date_span(p));
  endtask

  // sender stops until every queued span has come back
  task automatic pause_until_drained();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_spans.size() != 0) @(posedge clk);
  endtask

  task automatic report(input string what);
    mismatches++;
    if (mismatches <= 40) $display("%0t ns: %s", $time, what);
  endtask

  // --------------------------------------------------------------------------
  // Result side: random stalls plus the long hold-off on request
  // --------------------------------------------------------------------------

  always @(posedge clk) begin
    if (hold_req != 0) begin
      sink_wait = hold_req;
      hold_req  = 0;
    end
    if (sink_wait != 0) begin
      out_tready <= 1'b0;
      sink_wait--;
    end else if (sink_gaps_on && $urandom_range(99, 0) < 25) begin
      out_tready <= 1'b0;
      sink_wait = pick_gap() - 1;
    end else begin
      out_tready <= 1'b1;
    end
  end

  // every result transfer against the oldest expected span
  always @(posedge clk) begin
    span_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_spans.size() == 0) begin
        report("result transfer with no span pending");
      end else begin
        want = pending_spans.pop_front();
        if (out_tdata[dbd_pkg::CountW-1:0] !== want.days)
          report($sformatf("day_count %0d, expected %0d",
                           out_tdata[dbd_pkg::CountW-1:0], want.days));
        if (out_tuser !== want.order_err)
          report($sformatf("order_error %b, expected %b", out_tuser, want.order_err));
      end
    end
  end

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // start not strictly before end, including equal dates and all-ones fields
  task automatic test_order_errors();
    send_dates(pair_of(2024, 6, 15, 2024, 6, 15, 1'b0));
    send_dates(pair_of(2024, 6, 15, 2024, 6, 15, 1'b1));
    send_dates(pair_of(2025, 1, 1, 2024, 12, 31, 1'b0));
    send_dates(pair_of(2024, 7, 1, 2024, 6, 30, 1'b1));
    send_dates(pair_of(2024, 6, 16, 2024, 6, 15, 1'b0));
    send_dates(pair_of(16383, 15, 31, 16383, 15, 31, 1'b1));
  endtask

  // shortest and longest legal spans, and saturation past 22 bits
  task automatic test_span_extremes();
    send_dates(pair_of(1, 1, 1, 9999, 12, 31, 1'b0));
    send_dates(pair_of(1, 1, 1, 9999, 12, 31, 1'b1));
    send_dates(pair_of(1, 1, 1, 1, 1, 2, 1'b0));
    send_dates(pair_of(0, 0, 0, 16383, 15, 31, 1'b0));
  endtask

  // 4/100/400 rule across the end of February and whole years
  task automatic test_leap_rules();
    send_dates(pair_of(2000, 2, 28, 2000, 3, 1, 1'b0));
    send_dates(pair_of(1900, 2, 28, 1900, 3, 1, 1'b0));
    send_dates(pair_of(2024, 2, 28, 2024, 3, 1, 1'b1));
    send_dates(pair_of(2023, 2, 28, 2023, 3, 1, 1'b0));
    send_dates(pair_of(1999, 12, 31, 2000, 12, 31, 1'b0));
    send_dates(pair_of(2100, 1, 1, 2101, 1, 1, 1'b0));
  endtask

  // month zero, months past twelve, day zero, day past month end,
  // year zero and a span that goes negative
  task automatic test_odd_fields();
    send_dates(pair_of(2001, 0, 5, 2001, 1, 1, 1'b0));
    send_dates(pair_of(2001, 13, 1, 2002, 1, 1, 1'b0));
    send_dates(pair_of(2001, 15, 9, 2003, 14, 0, 1'b1));
    send_dates(pair_of(2001, 3, 0, 2001, 3, 1, 1'b0));
    send_dates(pair_of(2001, 4, 31, 2001, 5, 1, 1'b1));
    send_dates(pair_of(0, 3, 1, 1, 1, 1, 1'b0));
    send_dates(pair_of(2000, 0, 31, 2000, 1, 5, 1'b0));
    send_dates(pair_of(2000, 0, 31, 2000, 1, 5, 1'b1));
  endtask

  // valid pairs with random gaps, a drained pause and a stretch without idling
  task automatic test_random_dates();
    repeat (450) send_dates(rand_valid_pair());
    pause_until_drained();
    src_gaps_on  = 1'b0;
    sink_gaps_on = 1'b0;
    repeat (200) send_dates(rand_valid_pair());
    src_gaps_on  = 1'b1;
    sink_gaps_on = 1'b1;
    repeat (350) send_dates(rand_valid_pair());
  endtask

  // every field bit in both states, well outside the calendar too
  task automatic test_random_fields();
    repeat (400) send_dates(rand_raw_pair());
  endtask

  // receiver holds off long enough for the pipeline to fill and stall input
  task automatic test_backpressure();
    src_gaps_on = 1'b0;
    hold_req    = 120;
    repeat (60) send_dates(rand_valid_pair());
    hold_req = 80;
    repeat (40) send_dates(rand_raw_pair());
    src_gaps_on = 1'b1;
    repeat (150) send_dates(rand_valid_pair());
  endtask

  initial begin
    int unsigned waited;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_order_errors();
    test_span_extremes();
    test_leap_rules();
    test_odd_fields();
    test_random_dates();
    test_random_fields();
    test_backpressure();

    // let the last results out, then wait for anything stray
    in_tvalid <= 1'b0;
    waited = 0;
    while (pending_spans.size() != 0 && waited < 100000) begin
      @(posedge clk);
      waited++;
    end
    if (pending_spans.size() != 0)
      report($sformatf("%0d expected results never arrived", pending_spans.size()));
    repeat (16) @(posedge clk);

    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

/* filelist.f */
src/dbd_pkg.sv
src/dbd_ordinal.sv
src/days_between_dates.sv
test/tb.sv
